// ===== sv/lbpc_pkg.sv =====
// Shared types, constants and the blink time table for the LED blink controller.
`default_nettype none
package lbpc_pkg;

  localparam int NUM_LEDS  = 2;
  localparam int LED_IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int LINES_W   = 2;

  localparam int PERIOD_W  = 16;
  localparam int CODE_W    = 4;
  localparam int RUN_W     = 7;
  localparam int PAT_W     = 2 * CODE_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = PERIOD_W;

  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd100;
  localparam logic [CODE_W-1:0]   OFF_CODE_RST = 4'd0;
  localparam logic [CODE_W-1:0]   ON_CODE_RST  = 4'd15;

  // item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COMMIT_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_OFF    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_ON     = 2'd2;

  typedef struct packed {
    logic [RUN_W-1:0]    run_count;
    logic                lit;
    logic [PERIOD_W-1:0] commit_timer;
    logic [PAT_W-1:0]    cur_pat;
    logic [PAT_W-1:0]    staged_pat;
  } led_state_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] commit_period;
    logic [CODE_W-1:0]   always_off;
    logic [CODE_W-1:0]   always_on;
  } cfg_t;

  function automatic logic [RUN_W-1:0] time_lookup(input logic [CODE_W-1:0] code);
    logic [RUN_W-1:0] v;
    case (code)
      4'd0:    v = 7'd0;
      4'd1:    v = 7'd1;
      4'd2:    v = 7'd2;
      4'd3:    v = 7'd4;
      4'd4:    v = 7'd6;
      4'd5:    v = 7'd10;
      4'd6:    v = 7'd16;
      4'd7:    v = 7'd20;
      4'd8:    v = 7'd24;
      4'd9:    v = 7'd30;
      4'd10:   v = 7'd36;
      4'd11:   v = 7'd40;
      4'd12:   v = 7'd50;
      4'd13:   v = 7'd60;
      4'd14:   v = 7'd100;
      4'd15:   v = 7'h1F;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/lbpc_tick_unit.sv =====
// Shared per-tick update unit: advances one LED's commit timer and blink phase.
`default_nettype none
module lbpc_tick_unit (
  input  wire lbpc_pkg::led_state_t st_in,
  input  wire lbpc_pkg::cfg_t       cfg,
  output lbpc_pkg::led_state_t      st_out
);

  logic [lbpc_pkg::PERIOD_W-1:0] timer_dec;
  logic [lbpc_pkg::CODE_W-1:0]   on_c;
  logic [lbpc_pkg::CODE_W-1:0]   off_c;

  always_comb begin
    st_out    = st_in;
    timer_dec = st_in.commit_timer - 1'b1;
    st_out.commit_timer = timer_dec;
    if (timer_dec == '0) begin
      st_out.commit_timer = cfg.commit_period;
      st_out.cur_pat      = st_in.staged_pat;
    end
    on_c  = st_out.cur_pat[lbpc_pkg::PAT_W-1:lbpc_pkg::CODE_W];
    off_c = st_out.cur_pat[lbpc_pkg::CODE_W-1:0];
    if (st_in.run_count != '0) begin
      st_out.run_count = st_in.run_count - 1'b1;
    end else if (off_c == cfg.always_off) begin
      // off force wins over on force
      st_out.lit = 1'b0;
    end else if (on_c == cfg.always_on) begin
      st_out.lit = 1'b1;
    end else if (st_in.lit) begin
      st_out.run_count = lbpc_pkg::time_lookup(off_c);
      st_out.lit       = 1'b0;
    end else begin
      st_out.run_count = lbpc_pkg::time_lookup(on_c);
      st_out.lit       = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/led_blink_pattern_controller.sv =====
// Top level of the LED blink controller: sequencer, LED state, config and output register.
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid in_stall in_opcode in_led_index            | input
//          | in_on_code in_off_code in_apply_now                 |
//  out     | out_valid out_stall out_led_lines                   | output
//  cfg     | cfg_we cfg_index cfg_data                           | input
//
// A set-pattern item goes straight to the result load; a tick first walks every LED,
// one at a time, through the single update unit, then loads the output register.
// One item is in flight at a time; in_stall is high until its result is loaded.
// A stalled result holds in the output register; the loading cycle waits for it.
// Synchronous active-low reset restores config defaults; LED timers PERIOD_RST, rest zero.
`default_nettype none
module led_blink_pattern_controller (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_opcode,
  input  wire                                in_led_index,
  input  wire [lbpc_pkg::CODE_W-1:0]         in_on_code,
  input  wire [lbpc_pkg::CODE_W-1:0]         in_off_code,
  input  wire                                in_apply_now,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [lbpc_pkg::LINES_W-1:0]       out_led_lines,
  input  wire                                cfg_we,
  input  wire [lbpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [lbpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TICK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [lbpc_pkg::LED_IDX_W-1:0] LAST_LED =
    lbpc_pkg::LED_IDX_W'(lbpc_pkg::NUM_LEDS - 1);

  logic [1:0]                         state_r, state_nxt;
  logic [lbpc_pkg::LED_IDX_W-1:0]     cnt_r, cnt_nxt;
  lbpc_pkg::cfg_t                     cfg_r, cfg_nxt;
  lbpc_pkg::led_state_t               led_r   [lbpc_pkg::NUM_LEDS];
  lbpc_pkg::led_state_t               led_nxt [lbpc_pkg::NUM_LEDS];
  logic                               out_valid_r, out_valid_nxt;
  logic [lbpc_pkg::LINES_W-1:0]       out_lines_r, out_lines_nxt;
  logic [lbpc_pkg::LINES_W-1:0]       lines_now;
  lbpc_pkg::led_state_t               unit_out;
  logic                               in_acc;
  logic                               out_free;
  logic [lbpc_pkg::PAT_W-1:0]         new_pat;

  lbpc_tick_unit u_tick (
    .st_in  (led_r[cnt_r]),
    .cfg    (cfg_r),
    .st_out (unit_out)
  );

  assign in_stall      = (state_r != ST_IDLE);
  assign in_acc        = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_led_lines = out_lines_r;
  assign out_free      = !out_valid_r || !out_stall;
  assign new_pat       = {in_on_code, in_off_code};

  always_comb begin
    lines_now = '0;
    for (int n = 0; n < lbpc_pkg::NUM_LEDS && n < lbpc_pkg::LINES_W; n++) begin
      lines_now[n] = led_r[n].lit;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lbpc_pkg::CFG_COMMIT_PERIOD: cfg_nxt.commit_period = cfg_data;
        lbpc_pkg::CFG_ALWAYS_OFF:    cfg_nxt.always_off = cfg_data[lbpc_pkg::CODE_W-1:0];
        lbpc_pkg::CFG_ALWAYS_ON:     cfg_nxt.always_on  = cfg_data[lbpc_pkg::CODE_W-1:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_lines_nxt = out_lines_r;
    for (int n = 0; n < lbpc_pkg::NUM_LEDS; n++) begin
      led_nxt[n] = led_r[n];
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == lbpc_pkg::OP_TICK) begin
            state_nxt = ST_TICK;
            cnt_nxt   = '0;
          end else begin
            state_nxt = ST_DONE;
            for (int n = 0; n < lbpc_pkg::NUM_LEDS; n++) begin
              if (lbpc_pkg::LED_IDX_W'(in_led_index) == lbpc_pkg::LED_IDX_W'(n)) begin
                led_nxt[n].staged_pat = new_pat;
                if (in_apply_now) begin
                  led_nxt[n].cur_pat      = new_pat;
                  led_nxt[n].commit_timer = lbpc_pkg::PERIOD_W'(1);
                  led_nxt[n].run_count    = '0;
                end
              end
            end
          end
        end
      end
      ST_TICK: begin
        for (int n = 0; n < lbpc_pkg::NUM_LEDS; n++) begin
          if (cnt_r == lbpc_pkg::LED_IDX_W'(n)) begin
            led_nxt[n] = unit_out;
          end
        end
        if (cnt_r == LAST_LED) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_lines_nxt = lines_now;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{commit_period: lbpc_pkg::PERIOD_RST,
                       always_off:    lbpc_pkg::OFF_CODE_RST,
                       always_on:     lbpc_pkg::ON_CODE_RST};
      for (int n = 0; n < lbpc_pkg::NUM_LEDS; n++) begin
        led_r[n] <= '{run_count: '0, lit: 1'b0,
                      commit_timer: lbpc_pkg::PERIOD_RST,
                      cur_pat: '0, staged_pat: '0};
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
      for (int n = 0; n < lbpc_pkg::NUM_LEDS; n++) begin
        led_r[n] <= led_nxt[n];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_lines_r <= out_lines_nxt;
  end

  // a tick starts its LED sweep at entry zero
  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_opcode == lbpc_pkg::OP_TICK) |=> (state_r == ST_TICK && cnt_r == '0))
    else $error("tick did not start LED sweep at entry zero");

  // a set-pattern item goes straight to result load
  a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_opcode == lbpc_pkg::OP_SET) |=> (state_r == ST_DONE))
    else $error("set-pattern item did not go to result load");

  // a result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_lines_r)))
    else $error("pending result overwritten");

  // every loaded result retires the item and reopens the input
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && !in_stall))
    else $error("result load did not return to idle");

endmodule
`default_nettype wire

// ===== sim/tb_led_blink_pattern_controller.sv =====
// Self-checking testbench for the LED blink pattern controller.
`timescale 1ns / 100ps
module tb_led_blink_pattern_controller;

  localparam int CLK_HALF    = 5;
  localparam int RESET_CYC   = 11;
  localparam int CYCLE_LIMIT = 200000;
  // a tick walks every LED, then loads the output register
  localparam int SETTLE_CYC  = lbpc_pkg::NUM_LEDS + 6;

  // run length per blink code, code 0 in the low bits
  localparam logic [16*lbpc_pkg::RUN_W-1:0] RUN_BY_CODE = {
    7'd31, 7'd100, 7'd60, 7'd50, 7'd40, 7'd36, 7'd30, 7'd24,
    7'd20, 7'd16,  7'd10, 7'd6,  7'd4,  7'd2,  7'd1,  7'd0};

  typedef struct packed {
    logic                        opcode;
    logic                        led_idx;
    logic [lbpc_pkg::CODE_W-1:0] on_code;
    logic [lbpc_pkg::CODE_W-1:0] off_code;
    logic                        apply_now;
  } blink_cmd_t;

  logic                            clk           = 1'b0;
  logic                            rst_n         = 1'b0;
  logic                            in_valid      = 1'b0;
  wire                             in_stall;
  logic                            in_opcode     = 1'b0;
  logic                            in_led_index  = 1'b0;
  logic [lbpc_pkg::CODE_W-1:0]     in_on_code    = '0;
  logic [lbpc_pkg::CODE_W-1:0]     in_off_code   = '0;
  logic                            in_apply_now  = 1'b0;
  wire                             out_valid;
  logic                            out_stall     = 1'b0;
  wire  [lbpc_pkg::LINES_W-1:0]    out_led_lines;
  logic                            cfg_we        = 1'b0;
  logic [lbpc_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [lbpc_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

  // shadow of the LED state and registers
  logic [lbpc_pkg::RUN_W-1:0]    led_run    [lbpc_pkg::NUM_LEDS];
  logic                          led_lit    [lbpc_pkg::NUM_LEDS];
  logic [lbpc_pkg::PERIOD_W-1:0] led_timer  [lbpc_pkg::NUM_LEDS];
  logic [lbpc_pkg::PAT_W-1:0]    led_cur    [lbpc_pkg::NUM_LEDS];
  logic [lbpc_pkg::PAT_W-1:0]    led_staged [lbpc_pkg::NUM_LEDS];
  logic [lbpc_pkg::PERIOD_W-1:0] commit_period = lbpc_pkg::PERIOD_RST;
  logic [lbpc_pkg::CODE_W-1:0]   off_force     = lbpc_pkg::OFF_CODE_RST;
  logic [lbpc_pkg::CODE_W-1:0]   on_force      = lbpc_pkg::ON_CODE_RST;

  blink_cmd_t                   pending_cmds [$];
  blink_cmd_t                   cur_cmd;
  logic [lbpc_pkg::LINES_W-1:0] lines_due [$];
  logic [lbpc_pkg::LINES_W-1:0] lines_want;
  logic                         took_item = 1'b0;

  int n_queued   = 0;
  int n_taken    = 0;
  int n_checked  = 0;
  int n_settings = 1;
  int fails      = 0;
  int burst_left = 1;
  int gap_left   = 0;
  int stall_mode = 0;
  int stall_span = 0;
  int tb_cycle   = 0;

  led_blink_pattern_controller u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_led_index  (in_led_index),
    .in_on_code    (in_on_code),
    .in_off_code   (in_off_code),
    .in_apply_now  (in_apply_now),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_led_lines (out_led_lines),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // one tick for one LED: commit timer first, then the blink phase
  function automatic void tick_led(int n);
    logic [lbpc_pkg::CODE_W-1:0] on_c;
    logic [lbpc_pkg::CODE_W-1:0] off_c;
    int                          sel;
    led_timer[n] = led_timer[n] - 1'b1;
    if (led_timer[n] == '0) begin
      led_timer[n] = commit_period;
      led_cur[n]   = led_staged[n];
    end
    if (led_run[n] != '0) begin
      led_run[n] = led_run[n] - 1'b1;
    end else begin
      on_c  = led_cur[n][lbpc_pkg::PAT_W-1:lbpc_pkg::CODE_W];
      off_c = led_cur[n][lbpc_pkg::CODE_W-1:0];
      if (off_c == off_force) begin
        led_lit[n] = 1'b0;
      end else if (on_c == on_force) begin
        led_lit[n] = 1'b1;
      end else begin
        // run length comes from the code of the phase being entered
        sel        = led_lit[n] ? int'(off_c) : int'(on_c);
        led_run[n] = RUN_BY_CODE[sel*lbpc_pkg::RUN_W +: lbpc_pkg::RUN_W];
        led_lit[n] = ~led_lit[n];
      end
    end
  endfunction

  function automatic logic [lbpc_pkg::LINES_W-1:0] leds_after(blink_cmd_t c);
    logic [lbpc_pkg::LINES_W-1:0] lines;
    lines = '0;
    if (c.opcode == lbpc_pkg::OP_TICK) begin
      for (int n = 0; n < lbpc_pkg::NUM_LEDS; n++) tick_led(n);
    end else if (int'(c.led_idx) < lbpc_pkg::NUM_LEDS) begin
      if (c.apply_now) begin
        led_cur[c.led_idx]   = {c.on_code, c.off_code};
        led_timer[c.led_idx] = lbpc_pkg::PERIOD_W'(1);
        led_run[c.led_idx]   = '0;
      end
      led_staged[c.led_idx] = {c.on_code, c.off_code};
    end
    for (int n = 0; n < lbpc_pkg::NUM_LEDS && n < lbpc_pkg::LINES_W; n++) begin
      lines[n] = led_lit[n];
    end
    return lines;
  endfunction

  // codes lean toward the force codes and short run lengths
  function automatic logic [lbpc_pkg::CODE_W-1:0] pick_code(
    logic [lbpc_pkg::CODE_W-1:0] force_code);
    case ($urandom_range(0, 5))
      0:       return force_code;
      1, 2:    return lbpc_pkg::CODE_W'($urandom_range(0, 4));
      default: return lbpc_pkg::CODE_W'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic blink_cmd_t random_cmd(logic op);
    blink_cmd_t c;
    c.opcode    = op;
    c.led_idx   = 1'($urandom_range(0, 1));
    c.on_code   = pick_code(on_force);
    c.off_code  = pick_code(off_force);
    c.apply_now = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic queue_cmd(blink_cmd_t c);
    pending_cmds.push_back(c);
    n_queued++;
  endtask

  task automatic queue_set(logic idx, logic [lbpc_pkg::CODE_W-1:0] on_c,
                           logic [lbpc_pkg::CODE_W-1:0] off_c, logic now);
    blink_cmd_t c;
    c.opcode    = lbpc_pkg::OP_SET;
    c.led_idx   = idx;
    c.on_code   = on_c;
    c.off_code  = off_c;
    c.apply_now = now;
    queue_cmd(c);
  endtask

  // ticks carry random payload bits, which the block ignores
  task automatic queue_ticks(int count);
    repeat (count) queue_cmd(random_cmd(lbpc_pkg::OP_TICK));
  endtask

  task automatic write_reg(logic [lbpc_pkg::CFG_IDX_W-1:0] idx,
                           logic [lbpc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      lbpc_pkg::CFG_COMMIT_PERIOD: commit_period = data;
      lbpc_pkg::CFG_ALWAYS_OFF:    off_force     = data[lbpc_pkg::CODE_W-1:0];
      lbpc_pkg::CFG_ALWAYS_ON:     on_force      = data[lbpc_pkg::CODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (n_taken != n_queued || lines_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic run_setting(logic [lbpc_pkg::PERIOD_W-1:0] period,
                             logic [lbpc_pkg::CODE_W-1:0] off_c,
                             logic [lbpc_pkg::CODE_W-1:0] on_c, int count);
    int target;
    target = n_queued + count;
    write_reg(lbpc_pkg::CFG_COMMIT_PERIOD, period);
    write_reg(lbpc_pkg::CFG_ALWAYS_OFF, lbpc_pkg::CFG_DATA_W'(off_c));
    write_reg(lbpc_pkg::CFG_ALWAYS_ON, lbpc_pkg::CFG_DATA_W'(on_c));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
    while (n_queued < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) queue_cmd(random_cmd(1'($urandom_range(0, 1))));
      end else begin
        // a pattern or two, then enough ticks to watch it run
        repeat ($urandom_range(1, 2)) queue_cmd(random_cmd(lbpc_pkg::OP_SET));
        queue_ticks($urandom_range(1, 30));
      end
    end
    wait_idle();
  endtask

  // sender: bursts of items with random gaps between them
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took_item)) begin
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        cur_cmd = pending_cmds.pop_front();
        in_valid     <= 1'b1;
        in_opcode    <= cur_cmd.opcode;
        in_led_index <= cur_cmd.led_idx;
        in_on_code   <= cur_cmd.on_code;
        in_off_code  <= cur_cmd.off_code;
        in_apply_now <= cur_cmd.apply_now;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: stall behavior switches at random between modes
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 150);
    end
    stall_span--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 4) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ((stall_span % 7) < 3);
    endcase
  end

  // result check first, then predict the item taken at this edge
  always @(posedge clk) begin
    took_item <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (lines_due.size() == 0) begin
        $error("led_lines: no result expected, actual %0h", out_led_lines);
        fails++;
      end else begin
        lines_want = lines_due.pop_front();
        n_checked++;
        if (lines_want !== out_led_lines) begin
          $error("led_lines mismatch: expected %0h, actual %0h", lines_want, out_led_lines);
          fails++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      lines_due.push_back(leds_after({in_opcode, in_led_index, in_on_code, in_off_code,
                                      in_apply_now}));
      n_taken++;
    end
  end

  always @(posedge clk) begin
    tb_cycle++;
    if (tb_cycle > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d items taken", tb_cycle, n_taken,
               n_queued);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int n = 0; n < lbpc_pkg::NUM_LEDS; n++) begin
      led_run[n]    = '0;
      led_lit[n]    = 1'b0;
      led_timer[n]  = lbpc_pkg::PERIOD_RST;
      led_cur[n]    = '0;
      led_staged[n] = '0;
    end
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    queue_ticks(1);
    queue_set(1'b0, 4'd15, 4'd1, 1'b1);
    queue_ticks(1);
    queue_set(1'b1, 4'd1, 4'd2, 1'b1);
    queue_ticks(4);
    queue_set(1'b1, 4'd0, 4'd15, 1'b0);
    queue_set(1'b0, 4'd14, 4'd15, 1'b1);
    queue_ticks(3);
    // on and off both match their force codes: off wins
    queue_set(1'b1, 4'd15, 4'd0, 1'b1);
    queue_ticks(1);
    queue_set(1'b0, 4'd0, 4'd0, 1'b0);
    queue_set(1'b0, 4'd7, 4'd3, 1'b1);
    queue_ticks(2);
    wait_idle();

    run_setting(16'd1,     4'd0,  4'd15, 130);
    run_setting(16'hFFFF,  4'd15, 4'd0,  110);
    // zero period: a reload to zero wraps on the following tick
    run_setting(16'd0,     4'd5,  4'd5,  110);
    run_setting(16'd3,     4'd9,  4'd6,  150);
    run_setting(16'd2,     4'd0,  4'd15, 150);

    $display("covered %0d items under %0d register settings, %0d LED line results compared",
             n_taken, n_settings, n_checked);
    $display("commit periods 0, 1, 2, 3, 100 and 65535; force codes at both ends and equal");
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== led_blink_pattern_controller.f =====
sv/lbpc_pkg.sv
sv/lbpc_tick_unit.sv
sv/led_blink_pattern_controller.sv
sim/tb_led_blink_pattern_controller.sv
